[hw/rtl/hpnms_pkg.sv]
`default_nettype none
package hpnms_pkg;

   // geometry and field widths
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int DIM_BITS   = 10;
   localparam int SCORE_BITS = 16;
   localparam int VAL_BITS   = SCORE_BITS - 1;
   localparam int CHAN_BITS  = 6;

   // register reset values
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 10'd46;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 10'd46;
   localparam logic [VAL_BITS-1:0] THRESH_RESET = 15'd614;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // register indexes
   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH     = 2'd0,
      CSR_FRAME_HEIGHT    = 2'd1,
      CSR_SCORE_THRESHOLD = 2'd2
   } csr_index_type;

   // one result item
   typedef struct packed {
      logic                 last;
      logic [VAL_BITS-1:0]  score;
      logic [CHAN_BITS-1:0] chan;
      logic [ROW_BITS-1:0]  y;
      logic [COL_BITS-1:0]  x;
   } result_type;

   // per-item decision flags carried with the pixel
   typedef struct packed {
      logic interior;
      logic border;
      logic t_ge;
   } decide_type;

endpackage
`default_nettype wire

[hw/rtl/heatmap_peak_nms_3x3.sv]
`default_nettype none
// 3x3 non-maximum suppression on raster-order heatmap scores. One pixel is
// taken per cycle. Scores under the threshold count as zero; a pixel
// (x-1,y-1) is judged when pixel (x,y) arrives, a border pixel is judged on
// arrival, so an input transaction yields zero, one or two peak results,
// interior peak first, and tlast marks the last one. Results are built from
// the stage-one registers and pass through a four-entry
// queue; the input stalls while fewer than two queue slots are free, so the
// rate stays at one pixel per cycle as long as the result side keeps up.
// Both line stores share one 512 x 30 memory with one read and one write
// port; its contents are undefined after reset and need no clearing, since
// each entry is written in a frame before it is used there.
module heatmap_peak_nms_3x3 (
   input  wire         clock,
   input  wire         reset,
   // csr write channel
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [14:0] csr_data,
   // pixel stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,  // sample_score[15:0], channel_index[21:16], zero
   // peak stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,  // peak_x[8:0], peak_y[17:9], peak_channel[23:18],
                                   // peak_score[38:24], zero
   output logic        rsp_tlast   // last_in_run
);

   localparam int CB = hpnms_pkg::COL_BITS;
   localparam int RB = hpnms_pkg::ROW_BITS;
   localparam int VB = hpnms_pkg::VAL_BITS;
   localparam int HB = hpnms_pkg::CHAN_BITS;
   localparam int DB = hpnms_pkg::DIM_BITS;
   localparam int SB = hpnms_pkg::SCORE_BITS;
   localparam int QB = hpnms_pkg::QPTR_BITS;

   // configuration registers
   logic [DB-1:0] width_ff, height_ff;
   logic [VB-1:0] thresh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= hpnms_pkg::WIDTH_RESET;
         height_ff <= hpnms_pkg::HEIGHT_RESET;
         thresh_ff <= hpnms_pkg::THRESH_RESET;
      end else if (csr_valid) begin
         unique case (hpnms_pkg::csr_index_type'(csr_index))
            hpnms_pkg::CSR_FRAME_WIDTH:     width_ff  <= csr_data[DB-1:0];
            hpnms_pkg::CSR_FRAME_HEIGHT:    height_ff <= csr_data[DB-1:0];
            hpnms_pkg::CSR_SCORE_THRESHOLD: thresh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // last column and row index, clamped to the supported geometry
   logic [CB-1:0] w_last;
   logic [RB-1:0] h_last;

   always_comb begin
      if (width_ff == '0)
         w_last = '0;
      else if (width_ff > DB'(hpnms_pkg::MAX_WIDTH))
         w_last = CB'(hpnms_pkg::MAX_WIDTH - 1);
      else
         w_last = CB'(width_ff - DB'(1));
      if (height_ff == '0)
         h_last = '0;
      else if (height_ff > DB'(hpnms_pkg::MAX_HEIGHT))
         h_last = RB'(hpnms_pkg::MAX_HEIGHT - 1);
      else
         h_last = RB'(height_ff - DB'(1));
   end

   // input fields and handshake
   logic [SB-1:0] in_score;
   logic [HB-1:0] in_chan;
   logic          accept;
   logic          s1_valid_ff;
   logic          s1_fire;

   assign in_score   = req_tdata[SB-1:0];
   assign in_chan    = req_tdata[SB+HB-1:SB];
   assign req_tready = !s1_valid_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;

   // position counters
   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff >= w_last) begin
            col_in = '0;
            row_in = (row_ff >= h_last) ? '0 : row_ff + RB'(1);
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
   end

   // threshold and decision flags
   logic [VB-1:0]           t_val;
   hpnms_pkg::decide_type   dec;

   always_comb begin
      t_val = '0;
      if (!in_score[SB-1] && in_score[VB-1:0] >= thresh_ff)
         t_val = in_score[VB-1:0];
      dec.t_ge     = t_val >= thresh_ff;
      dec.interior = col_ff >= CB'(2) && col_ff <= w_last
                     && row_ff >= RB'(2) && row_ff <= h_last;
      dec.border   = col_ff == '0 || col_ff >= w_last
                     || row_ff == '0 || row_ff >= h_last;
   end

   // stage one registers
   logic [CB-1:0]          s1_x_ff;
   logic [RB-1:0]          s1_y_ff;
   logic [HB-1:0]          s1_chan_ff;
   logic [VB-1:0]          s1_t_ff;
   hpnms_pkg::decide_type  s1_dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         s1_valid_ff <= accept || (s1_valid_ff && !s1_fire);
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
      if (accept) begin
         s1_x_ff    <= col_ff;
         s1_y_ff    <= row_ff;
         s1_chan_ff <= in_chan;
         s1_t_ff    <= t_val;
         s1_dec_ff  <= dec;
      end
   end

   // line stores: upper half older row, lower half newer row
   logic [2*VB-1:0] line_mem [hpnms_pkg::MAX_WIDTH];
   logic [2*VB-1:0] line_rd_ff;
   logic [2*VB-1:0] byp_data_ff;
   logic            byp_ff;
   logic [2*VB-1:0] line_word;
   logic [VB-1:0]   above, mid;
   logic            byp_in;

   assign line_word = byp_ff ? byp_data_ff : line_rd_ff;
   assign above     = line_word[2*VB-1:VB];
   assign mid       = line_word[VB-1:0];
   // same column read while the previous write is still pending
   assign byp_in    = s1_fire && (s1_x_ff == col_ff);

   always_ff @(posedge clock) begin
      if (s1_fire)
         line_mem[s1_x_ff] <= {mid, s1_t_ff};
      if (accept) begin
         line_rd_ff  <= line_mem[col_ff];
         byp_data_ff <= {mid, s1_t_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         byp_ff <= 1'b0;
      else if (accept)
         byp_ff <= byp_in;
   end

   // window columns: col1 and col2 hold top, middle, bottom
   logic [VB-1:0] col1_ff [3];
   logic [VB-1:0] col2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            col1_ff[i] <= '0;
            col2_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         for (int i = 0; i < 3; i++)
            col1_ff[i] <= col2_ff[i];
         col2_ff[0] <= above;
         col2_ff[1] <= mid;
         col2_ff[2] <= s1_t_ff;
      end
   end

   // peak decision on the shifted window
   logic [VB-1:0] center;
   logic          is_max;
   logic          int_hit, bord_hit;

   assign center = col2_ff[1];
   assign is_max = center >= col1_ff[0] && center >= col1_ff[1]
                   && center >= col1_ff[2] && center >= col2_ff[0]
                   && center >= col2_ff[2] && center >= above
                   && center >= mid && center >= s1_t_ff;
   assign int_hit  = s1_dec_ff.interior && is_max && center >= thresh_ff;
   assign bord_hit = s1_dec_ff.border && s1_dec_ff.t_ge;

   // build up to two results
   hpnms_pkg::result_type int_res, bord_res, res0, res1;
   logic [1:0]            n_push;

   always_comb begin
      int_res.x     = s1_x_ff - CB'(1);
      int_res.y     = s1_y_ff - RB'(1);
      int_res.chan  = s1_chan_ff;
      int_res.score = center;
      int_res.last  = !bord_hit;
      bord_res.x     = s1_x_ff;
      bord_res.y     = s1_y_ff;
      bord_res.chan  = s1_chan_ff;
      bord_res.score = s1_t_ff;
      bord_res.last  = 1'b1;
      res0   = int_hit ? int_res : bord_res;
      res1   = bord_res;
      n_push = 2'(int_hit) + 2'(bord_hit);
   end

   // result queue
   hpnms_pkg::result_type queue_ff [hpnms_pkg::QUEUE_DEPTH];
   logic [QB-1:0]         wr_ff, rd_ff;
   logic [QB:0]           count_ff, count_in;
   logic                  pop;

   assign s1_fire = s1_valid_ff && (count_ff <= (QB+1)'(hpnms_pkg::QUEUE_DEPTH - 2));
   assign pop     = rsp_tvalid && rsp_tready;
   assign count_in = count_ff + (QB+1)'(s1_fire ? n_push : 2'd0) - (QB+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (pop)
            rd_ff <= rd_ff + QB'(1);
         if (s1_fire)
            wr_ff <= wr_ff + QB'(n_push);
      end
      if (s1_fire && n_push != 2'd0)
         queue_ff[wr_ff] <= res0;
      if (s1_fire && n_push == 2'd2)
         queue_ff[wr_ff + QB'(1)] <= res1;
   end

   // result outputs
   hpnms_pkg::result_type head;

   assign head       = queue_ff[rd_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {1'b0, head.score, head.chan, head.y, head.x};
   assign rsp_tlast  = head.last;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QB+1)'(hpnms_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_fire_room: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && n_push == 2'd2) |=> count_ff >= (QB+1)'(1))
      else $error("two results pushed but queue empty");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_x_ff) && $stable(s1_t_ff)))
      else $error("stalled pixel lost");

   a_bypass_width: assert property (@(posedge clock) disable iff (reset)
      (accept && byp_in) |-> (w_last == '0 || col_ff == '0))
      else $error("unexpected line store bypass");

endmodule
`default_nettype wire

[tb/tb_heatmap_peak_nms_3x3.sv]
`default_nettype none
module tb_heatmap_peak_nms_3x3;

   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PIXELS = 120;

   localparam int CB = hpnms_pkg::COL_BITS;
   localparam int RB = hpnms_pkg::ROW_BITS;
   localparam int VB = hpnms_pkg::VAL_BITS;
   localparam int DB = hpnms_pkg::DIM_BITS;
   localparam int MW = hpnms_pkg::MAX_WIDTH;
   localparam int MH = hpnms_pkg::MAX_HEIGHT;

   typedef enum {KIND_BLOB, KIND_PLATEAU, KIND_NOISE} frame_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = hpnms_pkg::CSR_FRAME_WIDTH;
   logic [14:0] csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   heatmap_peak_nms_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow copy of the detector state
   logic [VB-1:0] older_row [MW];
   logic [VB-1:0] newer_row [MW];
   logic [VB-1:0] win [9];
   int            col_pos;
   int            row_pos;
   logic [DB-1:0] width_reg;
   logic [DB-1:0] height_reg;
   logic [VB-1:0] thresh_reg;

   // peaks still owed by the block, oldest first
   hpnms_pkg::result_type peak_queue [$];
   hpnms_pkg::result_type due_peak;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int pixels_sent    = 0;
   int burst_left     = 0;
   bit sender_gaps    = 1'b1;
   bit no_stalls      = 1'b0;

   // plateau levels of the frame in flight
   logic [VB-1:0] level_lo;
   logic [VB-1:0] level_hi;

   // receiver stall pattern state
   int stall_mode   = 0;
   int pattern_left = 0;
   int pattern_step = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: switches among stall patterns at random intervals
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         stall_mode   = $urandom_range(0, 3);
         pattern_left = $urandom_range(50, 250);
         pattern_step = 0;
      end else begin
         pattern_left = pattern_left - 1;
         pattern_step = pattern_step + 1;
      end
      if (no_stalls) begin
         rsp_tready <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= ((pattern_step % 7) >= 3);
            default: rsp_tready <= ((pattern_step % 40) >= 18);
         endcase
      end
   end

   function automatic int eff_dim(logic [DB-1:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   task automatic clear_detector();
      int i;
      for (i = 0; i < MW; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = hpnms_pkg::WIDTH_RESET;
      height_reg = hpnms_pkg::HEIGHT_RESET;
      thresh_reg = hpnms_pkg::THRESH_RESET;
   endtask

   // advance the shadow detector by one pixel and queue the peaks it decides
   task automatic predict_peaks(input logic [15:0] score, input logic [5:0] chan);
      int                    w;
      int                    h;
      int                    x;
      int                    y;
      int                    n;
      int                    i;
      logic [VB-1:0]         t;
      logic [VB-1:0]         above;
      logic [VB-1:0]         mid;
      logic [VB-1:0]         m;
      hpnms_pkg::result_type found [2];
      w = eff_dim(width_reg, MW);
      h = eff_dim(height_reg, MH);
      x = col_pos;
      y = row_pos;
      n = 0;
      // negative or below-threshold scores count as zero
      t = '0;
      if (!score[15] && score[VB-1:0] >= thresh_reg) t = score[VB-1:0];
      above        = older_row[x];
      mid          = newer_row[x];
      older_row[x] = mid;
      newer_row[x] = t;
      for (i = 0; i < 3; i++) begin
         win[i*3]   = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = above;
      win[5] = mid;
      win[8] = t;
      // interior pixel one up and one left is judged against its window
      if (x >= 2 && x <= w - 1 && y >= 2 && y <= h - 1) begin
         m = '0;
         for (i = 0; i < 9; i++) if (win[i] > m) m = win[i];
         if (win[4] == m && win[4] >= thresh_reg) begin
            found[n].x     = CB'(x - 1);
            found[n].y     = RB'(y - 1);
            found[n].chan  = chan;
            found[n].score = win[4];
            found[n].last  = 1'b0;
            n++;
         end
      end
      // border pixel is judged against itself only
      if (x == 0 || x >= w - 1 || y == 0 || y >= h - 1) begin
         if (t >= thresh_reg) begin
            found[n].x     = CB'(x);
            found[n].y     = RB'(y);
            found[n].chan  = chan;
            found[n].score = t;
            found[n].last  = 1'b0;
            n++;
         end
      end
      if (n > 0) found[n-1].last = 1'b1;
      for (i = 0; i < n; i++) peak_queue.insert(peak_queue.size(), found[i]);
      // raster counters wrap against the current geometry
      if (x >= w - 1) begin
         col_pos = 0;
         row_pos = (y >= h - 1) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endtask

   task automatic note_mismatch(input string what, input hpnms_pkg::result_type want,
                                input bit has_want);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (has_want)
            $display("%s: expected x/y/ch/score/last %0d/%0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0d/%0b pad=%0b",
                     what, want.x, want.y, want.chan, want.score, want.last,
                     rsp_tdata[8:0], rsp_tdata[17:9], rsp_tdata[23:18], rsp_tdata[38:24],
                     rsp_tlast, rsp_tdata[39]);
         else
            $display("%s: got x=%0d y=%0d ch=%0d score=%0d last=%0b",
                     what, rsp_tdata[8:0], rsp_tdata[17:9], rsp_tdata[23:18],
                     rsp_tdata[38:24], rsp_tlast);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (peak_queue.size() == 0) begin
            note_mismatch("unexpected peak", due_peak, 1'b0);
         end else begin
            due_peak = peak_queue.pop_front();
            if (rsp_tdata[8:0] !== due_peak.x || rsp_tdata[17:9] !== due_peak.y ||
                rsp_tdata[23:18] !== due_peak.chan || rsp_tdata[38:24] !== due_peak.score ||
                rsp_tdata[39] !== 1'b0 || rsp_tlast !== due_peak.last)
               note_mismatch("peak mismatch", due_peak, 1'b1);
         end
      end
   end

   // one pixel transaction, with bursts and random gaps in front
   task automatic send_pixel(input logic [15:0] score, input logic [5:0] chan);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, chan, score};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_peaks(score, chan);
      pixels_sent++;
   endtask

   // stop sending and let every owed peak and the pipeline drain
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (peak_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input hpnms_pkg::csr_index_type idx, input logic [14:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         hpnms_pkg::CSR_FRAME_WIDTH:     width_reg  = value[DB-1:0];
         hpnms_pkg::CSR_FRAME_HEIGHT:    height_reg = value[DB-1:0];
         hpnms_pkg::CSR_SCORE_THRESHOLD: thresh_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // dimension writes carry random junk above the 10 register bits
   task automatic set_geometry(input int w, input int h, input int thr);
      wait_for_results();
      write_reg(hpnms_pkg::CSR_FRAME_WIDTH, {5'($urandom), 10'(w)});
      write_reg(hpnms_pkg::CSR_FRAME_HEIGHT, {5'($urandom), 10'(h)});
      write_reg(hpnms_pkg::CSR_SCORE_THRESHOLD, 15'(thr));
   endtask

   function automatic logic [15:0] pick_score(frame_kind_type kind);
      int          r;
      int          v;
      logic [15:0] s;
      r = $urandom_range(0, 9);
      case (kind)
         KIND_NOISE: s = 16'($urandom);
         KIND_PLATEAU: begin
            if (r == 9) s = {1'b1, 15'($urandom)};
            else begin
               case (r % 4)
                  0:       s = '0;
                  1:       s = {1'b0, thresh_reg};
                  2:       s = {1'b0, level_lo};
                  default: s = {1'b0, level_hi};
               endcase
            end
         end
         default: begin
            if (r <= 3) s = (thresh_reg == 0) ? 16'd0 : 16'($urandom_range(0, thresh_reg - 1));
            else if (r == 4) s = {1'b1, 15'($urandom)};
            else if (r <= 6) begin
               v = thresh_reg + $urandom_range(0, 3);
               if (v > 32767) v = 32767;
               s = 16'(v);
            end else s = 16'($urandom_range(thresh_reg, 32767));
         end
      endcase
      return s;
   endfunction

   // a run of pixels at the current geometry, not tied to frame bounds
   task automatic send_pixels(input frame_kind_type kind, input logic [5:0] chan,
                              input int count);
      int i;
      level_lo = 15'($urandom_range(thresh_reg, 32767));
      level_hi = 15'($urandom_range(level_lo, 32767));
      for (i = 0; i < count; i++) send_pixel(pick_score(kind), chan);
   endtask

   // a 1x1 geometry wraps both counters on the next pixel
   task automatic restart_frame();
      set_geometry(1, 1, int'(thresh_reg));
      send_pixel(pick_score(KIND_BLOB), 6'd0);
   endtask

   // one whole frame at the current geometry, optionally pausing part way
   task automatic send_frame(input frame_kind_type kind, input logic [5:0] chan,
                             input bit vary_chan, input int pause_at);
      int         total;
      int         i;
      logic [5:0] ch;
      total    = eff_dim(width_reg, MW) * eff_dim(height_reg, MH);
      level_lo = 15'($urandom_range(thresh_reg, 32767));
      level_hi = 15'($urandom_range(level_lo, 32767));
      for (i = 0; i < total; i++) begin
         if (i == pause_at) wait_for_results();
         ch = vary_chan ? 6'($urandom) : chan;
         send_pixel(pick_score(kind), ch);
      end
   endtask

   // power-on geometry and threshold, no register written yet: the first
   // rows and part of a third, then back to the frame origin
   task automatic test_reset_defaults();
      send_pixels(KIND_BLOB, 6'd0, 2 * eff_dim(width_reg, MW) + 10);
      restart_frame();
   endtask

   // hand-built 5x5 frame: score extremes, negatives, values around the
   // threshold, a kept plateau and peaks suppressed by larger neighbors
   task automatic test_directed_frame();
      logic [15:0] grid [25];
      int          i;
      grid = '{16'h8000, 16'h0266, 16'h0265, 16'hFFFF, 16'h7FFF,
               16'h0000, 16'h0384, 16'h0384, 16'h0064, 16'h0267,
               16'h0032, 16'h0384, 16'h0384, 16'h0064, 16'h0000,
               16'h0266, 16'h05DC, 16'h07CF, 16'h0BB8, 16'h0267,
               16'h0001, 16'h07D0, 16'hFD9A, 16'h0266, 16'h7FFF};
      set_geometry(5, 5, 614);
      for (i = 0; i < 25; i++) send_pixel(grid[i], 6'd63);
   endtask

   // frames under 3 in either direction are all border; zero acts as one
   task automatic test_small_frames();
      int dims [8][2];
      int i;
      dims = '{'{1, 1}, '{2, 2}, '{1, 4}, '{4, 1}, '{2, 5}, '{3, 3}, '{0, 3}, '{3, 0}};
      for (i = 0; i < 8; i++) begin
         set_geometry(dims[i][0], dims[i][1], 614);
         send_frame(KIND_BLOB, 6'($urandom), 1'b0, -1);
         send_frame(KIND_PLATEAU, 6'($urandom), 1'b0, -1);
      end
   endtask

   // zero threshold reports every border pixel and all-zero interiors; then the top threshold 32767
   task automatic test_threshold_extremes();
      set_geometry(4, 4, 0);
      send_frame(KIND_PLATEAU, 6'd21, 1'b0, -1);
      send_frame(KIND_NOISE, 6'd42, 1'b0, -1);
      set_geometry(4, 3, 32767);
      send_frame(KIND_PLATEAU, 6'd63, 1'b0, -1);
      send_frame(KIND_BLOB, 6'd0, 1'b0, -1);
   endtask

   // oversize width and height values clamp; partial frames, no idling here
   task automatic test_large_geometry();
      sender_gaps = 1'b0;
      no_stalls   = 1'b1;
      set_geometry(1023, 2, 614);
      send_pixels(KIND_BLOB, 6'd5, 40);
      restart_frame();
      set_geometry(3, 1023, 614);
      send_pixels(KIND_PLATEAU, 6'd6, 42);
      restart_frame();
      wait_for_results();
      sender_gaps = 1'b1;
      no_stalls   = 1'b0;
   endtask

   // random geometry, threshold and content, mostly small frames
   task automatic test_random_frames();
      int             start;
      int             r;
      int             w;
      int             h;
      int             thr;
      int             total;
      int             pause_at;
      bit             first;
      frame_kind_type kind;
      start = pixels_sent;
      first = 1'b1;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         r = $urandom_range(0, 9);
         if (r < 7) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
         end else if (r < 9) begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 24);
         end else begin
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 6);
         end
         r = $urandom_range(0, 9);
         if (r == 0) thr = 0;
         else if (r == 1) thr = $urandom_range(0, 32767);
         else if (r <= 4) thr = 614;
         else thr = $urandom_range(1, 4096);
         set_geometry(w, h, thr);
         r = $urandom_range(0, 9);
         kind = (r < 5) ? KIND_BLOB : (r < 8) ? KIND_PLATEAU : KIND_NOISE;
         total = w * h;
         // hold the sender mid-frame until all owed peaks are out
         pause_at = (first || $urandom_range(0, 5) == 0) ? total / 2 : -1;
         first = 1'b0;
         sender_gaps = ($urandom_range(0, 3) != 0);
         send_frame(kind, 6'($urandom), ($urandom_range(0, 7) == 0), pause_at);
      end
      sender_gaps = 1'b1;
   endtask

   initial begin
      clear_detector();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_frame();
      test_small_frames();
      test_threshold_extremes();
      test_large_geometry();
      test_random_frames();
      wait_for_results();
      if (mismatch_count == 0 && peak_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
